// File: hw/rtl/tsc_pkg.sv
// Shared types, state codes and constants of the telemetry session controller.
package tsc_pkg;

    // Session state codes as shown on the result stream.
    typedef enum logic [3:0] {
        S_DISC_SLEEP    = 4'd0,
        S_ENTER_SLEEP   = 4'd1,
        S_SLEEPING      = 4'd2,
        S_WAIT_BATTERY  = 4'd3,
        S_WAKING        = 4'd4,
        S_SNAPSHOT      = 4'd5,
        S_SEND_AUX      = 4'd6,
        S_WAIT_ACK      = 4'd7,
        S_RETRY         = 4'd8,
        S_RESULT_AUX    = 4'd9
    } t_sess;

    // Link status codes.
    localparam logic [2:0] LS_DISCONNECTED = 3'd0;
    localparam logic [2:0] LS_SLEEP        = 3'd1;
    localparam logic [2:0] LS_READY        = 3'd2;
    localparam logic [2:0] LS_SENDING      = 3'd3;
    localparam logic [2:0] LS_RETRY        = 3'd4;
    localparam logic [2:0] LS_SUCCESS      = 3'd5;
    localparam logic [2:0] LS_FAILED       = 3'd6;

    // Radio mode request codes.
    localparam logic [1:0] MODE_NONE   = 2'd0;
    localparam logic [1:0] MODE_SLEEP  = 2'd1;
    localparam logic [1:0] MODE_NORMAL = 2'd2;

    // Acknowledgement status codes.
    localparam logic [1:0] ACK_ST_OK  = 2'd0;
    localparam logic [1:0] ACK_ST_DUP = 2'd1;

    // Configuration register indexes.
    localparam logic [2:0] REG_NODE_ID       = 3'd0;
    localparam logic [2:0] REG_SESSION_SEED  = 3'd1;
    localparam logic [2:0] REG_SAMPLE_IVL    = 3'd2;
    localparam logic [2:0] REG_MODE_TIMEOUT  = 3'd3;
    localparam logic [2:0] REG_ACK_TIMEOUT   = 3'd4;
    localparam logic [2:0] REG_RETRY_DELAY   = 3'd5;
    localparam logic [2:0] REG_RESULT_DISP   = 3'd6;
    localparam logic [2:0] REG_MAX_RETRIES   = 3'd7;

    // Timing constants in milliseconds.
    localparam logic [31:0] AUX_STABLE_TIME  = 32'd2;
    localparam logic [31:0] MODE_SETTLE_TIME = 32'd20;

    // Width of the deadline arithmetic and of the remainder divider.
    localparam int          TIME_W     = 32;
    localparam logic [4:0]  DIV_LAST   = 5'd31;

    // Sequencer states.
    typedef enum logic [2:0] {
        C_IDLE = 3'd0,
        C_LOAD = 3'd1,
        C_DIV  = 3'd2,
        C_EXEC = 3'd3,
        C_OUT  = 3'd4
    } t_ctl_state;

    // Input request, last declared field in the lowest bits.
    typedef struct packed {
        logic [6:0]  pad;
        logic        send_ok;
        logic        mode_set_ok;
        logic [1:0]  ack_status;
        logic [31:0] ack_message;
        logic [15:0] ack_node;
        logic        ack_valid;
        logic        battery_ok;
        logic        battery_complete;
        logic        battery_granted;
        logic        aux_high;
        logic [31:0] now_ms;
    } t_item;

    // Result request, last declared field in the lowest bits.
    typedef struct packed {
        logic [6:0]  pad;
        logic        send_packet;
        logic        snapshot_take;
        logic        battery_request;
        logic [1:0]  mode_request;
        logic [4:0]  attempt_count;
        logic [31:0] message_id;
        logic [2:0]  link_status;
        logic [3:0]  session_state;
    } t_result;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic load;
        logic div_start;
        logic div_step;
        logic commit;
    } t_dp_cmd;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic need_div;
    } t_dp_stat;

endpackage

// File: hw/rtl/tsc_ctrl.sv
// Sequencer that steps one request through load, an optional divide, execute and output.
module tsc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    input  tsc_pkg::t_dp_stat i_stat,
    output tsc_pkg::t_dp_cmd  o_cmd
);

    tsc_pkg::t_ctl_state r_state, n_state;
    logic [4:0]          r_cnt, n_cnt;

    // State and divide step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tsc_pkg::C_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            tsc_pkg::C_IDLE: begin
                if (i_s_tvalid) n_state = tsc_pkg::C_LOAD;
            end
            tsc_pkg::C_LOAD: begin
                n_cnt = '0;
                n_state = i_stat.need_div ? tsc_pkg::C_DIV : tsc_pkg::C_EXEC;
            end
            tsc_pkg::C_DIV: begin
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == tsc_pkg::DIV_LAST) n_state = tsc_pkg::C_EXEC;
            end
            tsc_pkg::C_EXEC: begin
                n_state = tsc_pkg::C_OUT;
            end
            tsc_pkg::C_OUT: begin
                if (i_m_tready) n_state = tsc_pkg::C_IDLE;
            end
            default: begin
                n_state = tsc_pkg::C_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        o_m_tvalid = 1'b0;
        case (r_state)
            tsc_pkg::C_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            tsc_pkg::C_LOAD: begin
                o_cmd.div_start = 1'b1;
            end
            tsc_pkg::C_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            tsc_pkg::C_EXEC: begin
                o_cmd.commit = 1'b1;
            end
            tsc_pkg::C_OUT: begin
                o_m_tvalid = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// File: hw/rtl/tsc_dpath.sv
// Datapath: configuration, session state, deadline divider and result register.
module tsc_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tsc_pkg::t_dp_cmd  i_cmd,
    output tsc_pkg::t_dp_stat o_stat,
    input  logic [95:0]       i_data,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    output logic [55:0]       o_data
);

    // Configuration registers.
    logic [15:0] r_node_id;
    logic [31:0] r_seed;
    logic [30:0] r_ivl, r_mode_to, r_ack_to, r_retry_dly, r_disp;
    logic [3:0]  r_max_retries;

    // Latched request and result.
    tsc_pkg::t_item   r_in;
    tsc_pkg::t_result r_out, n_out;

    // Session state.
    logic [3:0]  r_fsm, n_fsm;
    logic [2:0]  r_status, n_status;
    logic [31:0] r_next, n_next;
    logic [31:0] r_started, n_started;
    logic [31:0] r_mode_at, n_mode_at;
    logic [31:0] r_aux_since, n_aux_since;
    logic [31:0] r_ack_at, n_ack_at;
    logic [31:0] r_retry_at, n_retry_at;
    logic [31:0] r_until, n_until;
    logic        r_hold, n_hold;
    logic        r_from_disc, n_from_disc;
    logic        r_aux_seen, n_aux_seen;
    logic [31:0] r_seq, n_seq;
    logic [4:0]  r_att, n_att;
    logic [31:0] r_cur_id, n_cur_id;

    // Remainder divider.
    logic [31:0] r_rem, r_dvd;
    logic [32:0] w_trial;
    logic [31:0] w_iv;

    // Shared step terms.
    logic [31:0] w_now, w_new_next, w_since_mode, w_since_start, w_since_ack;
    logic [31:0] w_disp_at, w_retry_at, w_seq1, w_id1, w_seq2, w_id2;
    logic [4:0]  w_att_inc;
    logic        w_reach_next, w_reach_until, w_reach_retry;
    logic        w_aux_stab, w_settle, w_mode_to, w_ack_hit;

    assign w_now          = r_in.now_ms;
    assign w_iv           = (r_ivl == '0) ? 32'd1 : {1'b0, r_ivl};
    assign w_reach_next   = ~(w_now - r_next) >> (tsc_pkg::TIME_W - 1) == 32'd1;
    assign w_reach_until  = ~(w_now - r_until) >> (tsc_pkg::TIME_W - 1) == 32'd1;
    assign w_reach_retry  = ~(w_now - r_retry_at) >> (tsc_pkg::TIME_W - 1) == 32'd1;
    assign w_since_mode   = w_now - r_mode_at;
    assign w_since_start  = w_now - r_started;
    assign w_since_ack    = w_now - r_ack_at;
    assign w_settle       = w_since_mode >= tsc_pkg::MODE_SETTLE_TIME;
    assign w_mode_to      = w_since_mode >= {1'b0, r_mode_to};
    assign w_aux_stab     = r_in.aux_high && r_aux_seen &&
                            ((w_now - r_aux_since) >= tsc_pkg::AUX_STABLE_TIME);
    assign w_disp_at      = w_now + {1'b0, r_disp};
    assign w_retry_at     = w_now + {1'b0, r_retry_dly};
    assign w_new_next     = w_now - r_rem + w_iv;
    assign w_att_inc      = r_att + 5'd1;
    assign w_seq1         = r_seq + 32'd1;
    assign w_id1          = r_seed + w_seq1;
    assign w_seq2         = r_seq + 32'd2;
    assign w_id2          = r_seed + w_seq2;
    assign w_ack_hit      = (r_fsm == tsc_pkg::S_SEND_AUX || r_fsm == tsc_pkg::S_WAIT_ACK ||
                             r_fsm == tsc_pkg::S_RETRY) && r_in.ack_valid &&
                            r_in.ack_node == r_node_id && r_in.ack_message == r_cur_id &&
                            (r_in.ack_status == tsc_pkg::ACK_ST_OK ||
                             r_in.ack_status == tsc_pkg::ACK_ST_DUP);

    // A new sample cycle from either sleep state needs the deadline remainder.
    assign o_stat.need_div = w_reach_next && !w_ack_hit &&
                             (r_fsm == tsc_pkg::S_SLEEPING || r_fsm == tsc_pkg::S_DISC_SLEEP ||
                              r_fsm > tsc_pkg::S_RESULT_AUX);
    assign o_data = r_out;

    // One restoring step of the remainder.
    assign w_trial = {r_rem, r_dvd[31]} - {1'b0, w_iv};

    // Divider registers: remainder of (now - deadline) by the interval.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_dvd <= w_now - r_next;
        end else if (i_cmd.div_step) begin
            r_rem <= w_trial[32] ? {r_rem[30:0], r_dvd[31]} : w_trial[31:0];
            r_dvd <= {r_dvd[30:0], 1'b0};
        end
    end

    // Request and result holding registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_in <= tsc_pkg::t_item'(i_data);
        if (i_cmd.commit) r_out <= n_out;
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_id     <= 16'd1;
            r_seed        <= 32'hA53C9E17;
            r_ivl         <= 31'd60000;
            r_mode_to     <= 31'd1000;
            r_ack_to      <= 31'd2000;
            r_retry_dly   <= 31'd500;
            r_disp        <= 31'd3000;
            r_max_retries <= 4'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tsc_pkg::REG_NODE_ID:      r_node_id     <= i_cfg_data[15:0];
                tsc_pkg::REG_SESSION_SEED: r_seed        <= i_cfg_data;
                tsc_pkg::REG_SAMPLE_IVL:   r_ivl         <= i_cfg_data[30:0];
                tsc_pkg::REG_MODE_TIMEOUT: r_mode_to     <= i_cfg_data[30:0];
                tsc_pkg::REG_ACK_TIMEOUT:  r_ack_to      <= i_cfg_data[30:0];
                tsc_pkg::REG_RETRY_DELAY:  r_retry_dly   <= i_cfg_data[30:0];
                tsc_pkg::REG_RESULT_DISP:  r_disp        <= i_cfg_data[30:0];
                tsc_pkg::REG_MAX_RETRIES:  r_max_retries <= i_cfg_data[3:0];
                default: r_node_id <= r_node_id;
            endcase
        end
    end

    // Session state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= tsc_pkg::S_DISC_SLEEP;
            r_status    <= tsc_pkg::LS_DISCONNECTED;
            r_next      <= '0;
            r_started   <= '0;
            r_mode_at   <= '0;
            r_aux_since <= '0;
            r_ack_at    <= '0;
            r_retry_at  <= '0;
            r_until     <= '0;
            r_hold      <= 1'b0;
            r_from_disc <= 1'b0;
            r_aux_seen  <= 1'b0;
            r_seq       <= '0;
            r_att       <= '0;
            r_cur_id    <= '0;
        end else if (i_cmd.commit) begin
            r_fsm       <= n_fsm;
            r_status    <= n_status;
            r_next      <= n_next;
            r_started   <= n_started;
            r_mode_at   <= n_mode_at;
            r_aux_since <= n_aux_since;
            r_ack_at    <= n_ack_at;
            r_retry_at  <= n_retry_at;
            r_until     <= n_until;
            r_hold      <= n_hold;
            r_from_disc <= n_from_disc;
            r_aux_seen  <= n_aux_seen;
            r_seq       <= n_seq;
            r_att       <= n_att;
            r_cur_id    <= n_cur_id;
        end
    end

    // One tick of the session: later assignments override earlier ones.
    always_comb begin
        logic [1:0] mode;
        logic       batt, snap, send, stab_call, do_send, do_disc, do_sleep;
        logic       do_start, start_fd, do_cancel, cancel_fd, do_fail;
        mode = tsc_pkg::MODE_NONE;
        batt = 1'b0; snap = 1'b0; send = 1'b0;
        stab_call = 1'b0; do_send = 1'b0; do_disc = 1'b0; do_sleep = 1'b0;
        do_start = 1'b0; start_fd = 1'b0; do_cancel = 1'b0; cancel_fd = r_from_disc;
        do_fail = 1'b0;
        n_fsm = r_fsm; n_status = r_status; n_next = r_next; n_started = r_started;
        n_mode_at = r_mode_at; n_aux_since = r_aux_since; n_ack_at = r_ack_at;
        n_retry_at = r_retry_at; n_until = r_until; n_hold = r_hold;
        n_from_disc = r_from_disc; n_aux_seen = r_aux_seen; n_seq = r_seq;
        n_att = r_att; n_cur_id = r_cur_id;

        if (w_ack_hit) begin
            n_status = tsc_pkg::LS_SUCCESS;
            n_until = w_disp_at;
            n_hold = 1'b1;
            n_fsm = tsc_pkg::S_RESULT_AUX;
            n_started = w_now;
        end else begin
            case (r_fsm)
                tsc_pkg::S_ENTER_SLEEP, tsc_pkg::S_WAKING: begin
                    stab_call = w_settle;
                    if (w_settle && w_aux_stab) begin
                        if (r_fsm == tsc_pkg::S_WAKING) begin
                            n_status = tsc_pkg::LS_READY;
                            n_fsm = tsc_pkg::S_SNAPSHOT;
                        end else begin
                            n_fsm = tsc_pkg::S_SLEEPING;
                        end
                        n_started = w_now;
                    end else if (w_mode_to) begin
                        do_disc = 1'b1;
                    end
                end
                tsc_pkg::S_SLEEPING: begin
                    if (r_hold && w_reach_until) begin
                        n_hold = 1'b0;
                        n_status = tsc_pkg::LS_SLEEP;
                    end
                    do_start = w_reach_next;
                end
                tsc_pkg::S_WAIT_BATTERY: begin
                    if (r_in.battery_complete) begin
                        if (!r_in.battery_ok) begin
                            do_cancel = 1'b1;
                        end else begin
                            mode = tsc_pkg::MODE_NORMAL;
                            if (!r_in.mode_set_ok) begin
                                do_disc = 1'b1;
                            end else begin
                                n_mode_at = w_now;
                                n_aux_seen = r_in.aux_high;
                                n_aux_since = w_now;
                                n_fsm = tsc_pkg::S_WAKING;
                                n_started = w_now;
                            end
                        end
                    end
                end
                tsc_pkg::S_SNAPSHOT: begin
                    if (!r_in.battery_ok) begin
                        n_status = tsc_pkg::LS_FAILED;
                        n_until = w_disp_at;
                        n_hold = 1'b1;
                        do_sleep = 1'b1;
                    end else begin
                        snap = 1'b1;
                        if (w_id1 == '0) begin
                            n_seq = w_seq2;
                            n_cur_id = w_id2;
                        end else begin
                            n_seq = w_seq1;
                            n_cur_id = w_id1;
                        end
                        n_att = '0;
                        n_from_disc = 1'b0;
                        n_fsm = tsc_pkg::S_SEND_AUX;
                        n_started = w_now;
                    end
                end
                tsc_pkg::S_SEND_AUX: begin
                    stab_call = 1'b1;
                    if (w_aux_stab) do_send = 1'b1;
                    else if (w_since_start >= {1'b0, r_mode_to}) do_disc = 1'b1;
                end
                tsc_pkg::S_WAIT_ACK: begin
                    if (w_since_ack >= {1'b0, r_ack_to}) begin
                        if (r_att <= {1'b0, r_max_retries}) begin
                            n_status = tsc_pkg::LS_RETRY;
                            n_retry_at = w_retry_at;
                            n_fsm = tsc_pkg::S_RETRY;
                            n_started = w_now;
                        end else begin
                            do_fail = 1'b1;
                        end
                    end
                end
                tsc_pkg::S_RETRY: begin
                    stab_call = w_reach_retry;
                    do_send = w_reach_retry && w_aux_stab;
                end
                tsc_pkg::S_RESULT_AUX: begin
                    stab_call = 1'b1;
                    do_sleep = w_aux_stab || (w_since_start >= {1'b0, r_mode_to});
                end
                default: begin
                    n_fsm = tsc_pkg::S_DISC_SLEEP;
                    do_start = w_reach_next;
                    start_fd = 1'b1;
                end
            endcase
        end

        // Ready pin tracking when the stability check is evaluated.
        if (stab_call) begin
            if (!r_in.aux_high) begin
                n_aux_seen = 1'b0;
            end else if (!r_aux_seen) begin
                n_aux_seen = 1'b1;
                n_aux_since = w_now;
            end
        end

        // Send the packet and account for the attempt.
        if (do_send) begin
            send = 1'b1;
            n_att = w_att_inc;
            if (!r_in.send_ok) begin
                if (w_att_inc <= {1'b0, r_max_retries}) begin
                    n_status = tsc_pkg::LS_RETRY;
                    n_retry_at = w_retry_at;
                    n_fsm = tsc_pkg::S_RETRY;
                    n_started = w_now;
                end else begin
                    do_fail = 1'b1;
                end
            end else begin
                n_status = tsc_pkg::LS_SENDING;
                n_ack_at = w_now;
                n_fsm = tsc_pkg::S_WAIT_ACK;
                n_started = w_now;
                n_aux_seen = 1'b0;
            end
        end

        // Session ends in failure.
        if (do_fail) begin
            n_status = tsc_pkg::LS_FAILED;
            n_until = w_disp_at;
            n_hold = 1'b1;
            n_fsm = tsc_pkg::S_RESULT_AUX;
            n_started = w_now;
        end

        // Start a sample cycle with a drift-free deadline advance.
        if (do_start) begin
            n_next = w_new_next;
            n_from_disc = start_fd;
            batt = 1'b1;
            if (!r_in.battery_granted) begin
                do_cancel = 1'b1;
                cancel_fd = start_fd;
            end else begin
                n_fsm = tsc_pkg::S_WAIT_BATTERY;
                n_started = w_now;
            end
        end

        // Abandon the cycle.
        if (do_cancel) begin
            n_started = w_now;
            if (cancel_fd) begin
                n_status = tsc_pkg::LS_DISCONNECTED;
                n_fsm = tsc_pkg::S_DISC_SLEEP;
            end else begin
                n_status = tsc_pkg::LS_FAILED;
                n_until = w_disp_at;
                n_hold = 1'b1;
                n_fsm = tsc_pkg::S_SLEEPING;
            end
            n_from_disc = 1'b0;
        end

        // Put the radio back to sleep after a result.
        if (do_sleep) begin
            mode = tsc_pkg::MODE_SLEEP;
            if (!r_in.mode_set_ok) begin
                do_disc = 1'b1;
            end else begin
                n_mode_at = w_now;
                n_aux_seen = r_in.aux_high;
                n_aux_since = w_now;
                n_fsm = tsc_pkg::S_ENTER_SLEEP;
                n_started = w_now;
            end
        end

        // Fall back to disconnected sleep.
        if (do_disc) begin
            n_status = tsc_pkg::LS_DISCONNECTED;
            mode = tsc_pkg::MODE_SLEEP;
            n_from_disc = 1'b0;
            n_fsm = tsc_pkg::S_DISC_SLEEP;
            n_started = w_now;
            n_aux_seen = 1'b0;
        end

        n_out.pad             = '0;
        n_out.send_packet     = send;
        n_out.snapshot_take   = snap;
        n_out.battery_request = batt;
        n_out.mode_request    = mode;
        n_out.attempt_count   = n_att;
        n_out.message_id      = n_cur_id;
        n_out.link_status     = n_status;
        n_out.session_state   = n_fsm;
    end

endmodule

// File: hw/rtl/telemetry_session_controller_core.sv
// Top level of the telemetry session controller.
//
// Each input request on the s_axis channel is one millisecond tick: the time,
// the radio ready pin, the battery handshake flags, one parsed acknowledgement
// and the mode change and send outcomes. For each tick the block returns one
// result request on m_axis with the session state, link status, message id,
// attempt count, the radio mode request and the action strobes.
// A plain tick passes through the load, execute and output states before its
// result is shown; a tick that starts a new sample cycle first runs a
// 32-step restoring remainder divider for the deadline advance between load
// and execute. One tick is worked on at a time; the next is accepted the
// cycle after its result is taken, and any receiver stall delays it.
// Configuration writes on the cfg channel are always taken and should be made
// only while no tick is in flight. When the receiver holds m_axis_tready low
// the result stays put and no new tick is accepted.
// Reset (i_rst_n low, synchronous) restores the register defaults and puts the
// session into disconnected sleep with every deadline at zero.
module telemetry_session_controller_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tdata: now_ms, aux_high, battery_granted, battery_complete, battery_ok,
    // ack_valid, ack_node, ack_message, ack_status, mode_set_ok, send_ok
    input  logic [95:0] s_axis_tdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: session_state, link_status, message_id, attempt_count,
    // mode_request, battery_request, snapshot_take, send_packet
    output logic [55:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    tsc_pkg::t_dp_cmd  w_cmd;
    tsc_pkg::t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;

    // Sequencer.
    tsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // Datapath.
    tsc_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_data      (s_axis_tdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_data      (m_axis_tdata)
    );

endmodule
